>>> sv/hrp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request parser package
// Shared constants, codes, character class type and name table for the
// HTTP request parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int VER_W               = 10;
  localparam int BODY_LEN_W          = 32;
  localparam int NAME_LEN            = 14;
  localparam int NAME_POS_W          = 4;
  localparam logic [VER_W-1:0] VER_MAX = 10'd999;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_H     = 8'h48;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_P     = 8'h50;

  typedef enum logic [1:0] {
    STATUS_PENDING  = 2'd0,
    STATUS_COMPLETE = 2'd1,
    STATUS_BAD      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ROLE_NONE         = 3'd0,
    ROLE_METHOD       = 3'd1,
    ROLE_URI          = 3'd2,
    ROLE_HEADER_NAME  = 3'd3,
    ROLE_HEADER_VALUE = 3'd4,
    ROLE_BODY         = 3'd5
  } role_t;

  typedef struct packed {
    logic token;
    logic ctl;
    logic digit;
    logic space_tab;
  } char_class_t;

  typedef struct packed {
    status_t          status;
    role_t            role;
    logic [7:0]       data;
    logic             header_begin;
    logic [VER_W-1:0] major;
    logic [VER_W-1:0] minor;
  } result_t;

  function automatic logic [7:0] name_char(input logic [NAME_POS_W-1:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h43;
      4'd1:    ch = 8'h6f;
      4'd2:    ch = 8'h6e;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6e;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2d;
      4'd8:    ch = 8'h4c;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6e;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> sv/hrp_char_class.sv
// ----------------------------------------------------------------------------
// HTTP request parser character classifier
// Sorts one byte into token, control, digit and linear whitespace classes.
// ----------------------------------------------------------------------------
module hrp_char_class
  import hrp_pkg::*;
(
  input  logic [7:0]  data,
  output char_class_t cls
);

  logic separator;

  always_comb begin
    separator = data inside {8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b,
                             8'h3a, 8'h5c, 8'h22, 8'h2f, 8'h5b, 8'h5d, 8'h3f,
                             8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09};
    cls.ctl       = (data <= 8'd31) || (data == 8'd127);
    cls.digit     = data inside {[8'h30:8'h39]};
    cls.space_tab = (data == CHAR_SPACE) || (data == CHAR_TAB);
    cls.token     = (data <= 8'd127) && !cls.ctl && !separator;
  end

endmodule

>>> sv/hrp_engine.sv
// ----------------------------------------------------------------------------
// HTTP request parser engine
// Holds the parse state and counters and works out the result for one byte.
// ----------------------------------------------------------------------------
module hrp_engine
  import hrp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic [7:0]             data,
  output result_t                result,
  output logic [LENGTH_BITS-1:0] length_out
);

  localparam int ACC_W = LENGTH_BITS + 4;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  typedef enum logic [4:0] {
    S_METHOD_START, S_METHOD, S_URI, S_H, S_T1, S_T2, S_P, S_SLASH,
    S_MAJ_START, S_MAJ, S_MIN_START, S_MIN, S_NL1, S_LINE_START,
    S_LWS, S_NAME, S_SPACE, S_VALUE, S_NL2, S_NL3, S_BODY
  } state_t;

  state_t                  state, state_next;
  logic [VER_W-1:0]        major_count, major_upd, major_count_next;
  logic [VER_W-1:0]        minor_count, minor_upd, minor_count_next;
  logic                    any_header_seen, any_header_seen_next;
  logic [NAME_POS_W-1:0]   name_match_pos, name_match_pos_next;
  logic                    name_still_matches, name_still_matches_next;
  logic                    current_is_length, current_is_length_next;
  logic                    has_body, has_body_next;
  logic [LENGTH_BITS-1:0]  length_value, length_upd, length_value_next;
  logic                    digits_ended, digits_ended_next;
  logic [LENGTH_BITS-1:0]  body_count, body_count_next;

  char_class_t             cls;
  logic [ACC_W-1:0]        len_acc;
  logic [LENGTH_BITS-1:0]  len_digit;
  logic [LENGTH_BITS-1:0]  length_byte;
  logic                    digits_ended_byte;
  logic                    name_full_match;
  status_t                 status;
  role_t                   role;
  logic                    hbeg;

  hrp_char_class u_char_class (
    .data (data),
    .cls  (cls)
  );

  function automatic logic [VER_W-1:0] ver_acc(input logic [VER_W-1:0] v,
                                               input logic [7:0] c);
    logic [13:0] n;
    n = 14'({v, 3'b000}) + 14'({v, 1'b0}) + 14'(c[3:0]);
    return (n > 14'(VER_MAX)) ? VER_MAX : n[VER_W-1:0];
  endfunction

  // Decimal accumulation of the length value, saturating at all ones.
  always_comb begin
    len_acc   = ACC_W'({length_value, 3'b000}) + ACC_W'({length_value, 1'b0}) +
                ACC_W'(data[3:0]);
    len_digit = (len_acc[ACC_W-1:LENGTH_BITS] != '0) ? LEN_MAX
                                                      : len_acc[LENGTH_BITS-1:0];
    length_byte       = length_value;
    digits_ended_byte = digits_ended;
    if (current_is_length && !digits_ended) begin
      if (cls.digit) begin
        length_byte = len_digit;
      end else begin
        digits_ended_byte = 1'b1;
      end
    end
  end

  assign name_full_match = name_still_matches &&
                           (name_match_pos == NAME_POS_W'(NAME_LEN));

  always_comb begin
    state_next              = state;
    major_upd               = major_count;
    minor_upd               = minor_count;
    any_header_seen_next    = any_header_seen;
    name_match_pos_next     = name_match_pos;
    name_still_matches_next = name_still_matches;
    current_is_length_next  = current_is_length;
    has_body_next           = has_body;
    length_upd              = length_value;
    digits_ended_next       = digits_ended;
    body_count_next         = body_count;
    status                  = STATUS_PENDING;
    role                    = ROLE_NONE;
    hbeg                    = 1'b0;

    case (state)
      S_BODY: begin
        role = ROLE_BODY;
        if (body_count < LEN_MAX) begin
          body_count_next = body_count + LENGTH_BITS'(1);
        end
        if (body_count_next == length_value) begin
          status = STATUS_COMPLETE;
        end
      end
      S_METHOD_START: begin
        if (!cls.token) begin
          status = STATUS_BAD;
        end else begin
          role       = ROLE_METHOD;
          state_next = S_METHOD;
        end
      end
      S_METHOD: begin
        if (data == CHAR_SPACE) begin
          state_next = S_URI;
        end else if (!cls.token) begin
          status = STATUS_BAD;
        end else begin
          role = ROLE_METHOD;
        end
      end
      S_URI: begin
        if (data == CHAR_SPACE) begin
          state_next = S_H;
        end else if (cls.ctl) begin
          status = STATUS_BAD;
        end else begin
          role = ROLE_URI;
        end
      end
      S_H: begin
        if (data == CHAR_H) state_next = S_T1;
        else status = STATUS_BAD;
      end
      S_T1: begin
        if (data == CHAR_T) state_next = S_T2;
        else status = STATUS_BAD;
      end
      S_T2: begin
        if (data == CHAR_T) state_next = S_P;
        else status = STATUS_BAD;
      end
      S_P: begin
        if (data == CHAR_P) state_next = S_SLASH;
        else status = STATUS_BAD;
      end
      S_SLASH: begin
        if (data == CHAR_SLASH) begin
          major_upd  = '0;
          minor_upd  = '0;
          state_next = S_MAJ_START;
        end else begin
          status = STATUS_BAD;
        end
      end
      S_MAJ_START: begin
        if (cls.digit) begin
          major_upd  = ver_acc(major_count, data);
          state_next = S_MAJ;
        end else begin
          status = STATUS_BAD;
        end
      end
      S_MAJ: begin
        if (data == CHAR_DOT) begin
          state_next = S_MIN_START;
        end else if (cls.digit) begin
          major_upd = ver_acc(major_count, data);
        end else begin
          status = STATUS_BAD;
        end
      end
      S_MIN_START: begin
        if (cls.digit) begin
          minor_upd  = ver_acc(minor_count, data);
          state_next = S_MIN;
        end else begin
          status = STATUS_BAD;
        end
      end
      S_MIN: begin
        if (data == CHAR_CR) begin
          state_next = S_NL1;
        end else if (cls.digit) begin
          minor_upd = ver_acc(minor_count, data);
        end else begin
          status = STATUS_BAD;
        end
      end
      S_NL1: begin
        if (data == CHAR_LF) state_next = S_LINE_START;
        else status = STATUS_BAD;
      end
      S_LINE_START: begin
        if (data == CHAR_CR) begin
          state_next = S_NL3;
        end else if (any_header_seen && cls.space_tab) begin
          state_next = S_LWS;
        end else if (!cls.token) begin
          status = STATUS_BAD;
        end else begin
          role                    = ROLE_HEADER_NAME;
          hbeg                    = 1'b1;
          any_header_seen_next    = 1'b1;
          current_is_length_next  = 1'b0;
          name_still_matches_next = (data == name_char('0));
          name_match_pos_next     = (data == name_char('0)) ? NAME_POS_W'(1) : '0;
          state_next              = S_NAME;
        end
      end
      S_LWS: begin
        if (data == CHAR_CR) begin
          state_next = S_NL2;
        end else if (cls.space_tab) begin
          state_next = S_LWS;
        end else if (cls.ctl) begin
          status = STATUS_BAD;
        end else begin
          role              = ROLE_HEADER_VALUE;
          length_upd        = length_byte;
          digits_ended_next = digits_ended_byte;
          state_next        = S_VALUE;
        end
      end
      S_NAME: begin
        if (data == CHAR_COLON) begin
          state_next = S_SPACE;
          if (name_full_match) begin
            has_body_next          = 1'b1;
            current_is_length_next = 1'b1;
            length_upd             = '0;
            digits_ended_next      = 1'b0;
          end
        end else if (!cls.token) begin
          status = STATUS_BAD;
        end else begin
          role = ROLE_HEADER_NAME;
          if (name_still_matches && (name_match_pos < NAME_POS_W'(NAME_LEN)) &&
              (data == name_char(name_match_pos))) begin
            name_match_pos_next = name_match_pos + NAME_POS_W'(1);
          end else begin
            name_still_matches_next = 1'b0;
          end
        end
      end
      S_SPACE: begin
        if (data == CHAR_SPACE) state_next = S_VALUE;
        else status = STATUS_BAD;
      end
      S_VALUE: begin
        if (data == CHAR_CR) begin
          state_next = S_NL2;
        end else if (cls.ctl) begin
          status = STATUS_BAD;
        end else begin
          role              = ROLE_HEADER_VALUE;
          length_upd        = length_byte;
          digits_ended_next = digits_ended_byte;
        end
      end
      S_NL2: begin
        if (data == CHAR_LF) state_next = S_LINE_START;
        else status = STATUS_BAD;
      end
      S_NL3: begin
        if (data != CHAR_LF) begin
          status = STATUS_BAD;
        end else if (has_body && (length_value != '0)) begin
          state_next = S_BODY;
        end else begin
          status = STATUS_COMPLETE;
        end
      end
      default: begin
        status = STATUS_BAD;
      end
    endcase

    major_count_next  = major_upd;
    minor_count_next  = minor_upd;
    length_value_next = length_upd;

    // A finished request, good or bad, puts the whole parser back to reset.
    if (status != STATUS_PENDING) begin
      state_next              = S_METHOD_START;
      major_count_next        = '0;
      minor_count_next        = '0;
      any_header_seen_next    = 1'b0;
      name_match_pos_next     = '0;
      name_still_matches_next = 1'b1;
      current_is_length_next  = 1'b0;
      has_body_next           = 1'b0;
      length_value_next       = '0;
      digits_ended_next       = 1'b0;
      body_count_next         = '0;
    end
  end

  always_comb begin
    result.status       = status;
    result.role         = role;
    result.data         = (role != ROLE_NONE) ? data : 8'h00;
    result.header_begin = hbeg;
    result.major        = major_upd;
    result.minor        = minor_upd;
    length_out          = length_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_METHOD_START;
      major_count        <= '0;
      minor_count        <= '0;
      any_header_seen    <= 1'b0;
      name_match_pos     <= '0;
      name_still_matches <= 1'b1;
      current_is_length  <= 1'b0;
      has_body           <= 1'b0;
      length_value       <= '0;
      digits_ended       <= 1'b0;
      body_count         <= '0;
    end else if (advance) begin
      state              <= state_next;
      major_count        <= major_count_next;
      minor_count        <= minor_count_next;
      any_header_seen    <= any_header_seen_next;
      name_match_pos     <= name_match_pos_next;
      name_still_matches <= name_still_matches_next;
      current_is_length  <= current_is_length_next;
      has_body           <= has_body_next;
      length_value       <= length_value_next;
      digits_ended       <= digits_ended_next;
      body_count         <= body_count_next;
    end
  end

endmodule

>>> sv/http_request_parser_unit.sv
// ----------------------------------------------------------------------------
// HTTP request parser unit
// Byte-serial HTTP/1.1 request header parser with body length tracking.
// ----------------------------------------------------------------------------
// The input channel carries one raw request byte per transaction on
// data_byte, qualified by in_valid and held off by in_stall. The output
// channel gives exactly one result per input byte: its status, role, the byte
// itself, a header start mark, the version numbers and the Content-Length
// value, qualified by out_valid and held off by out_stall.
// Each byte passes through an input register and an output register: its
// result is worked out from the input register and held in the output
// register. One byte per cycle is sustained while out_stall is low; the state
// update for a byte is a single pass of logic between those two registers.
// While the output register holds a result that is stalled, the input
// register still takes one more byte; in_stall rises only when both are full.
// Reset empties both registers and puts the parser at the start of a method
// token. After a complete or malformed request the parser returns there by
// itself, so the next byte begins a new request.
// ----------------------------------------------------------------------------
module http_request_parser_unit
  import hrp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            parse_status,
  output logic [2:0]            byte_role,
  output logic [7:0]            byte_out,
  output logic                  header_begin,
  output logic [VER_W-1:0]      version_major,
  output logic [VER_W-1:0]      version_minor,
  output logic [BODY_LEN_W-1:0] body_length
);

  logic                   in_full;
  logic [7:0]             in_byte;
  logic                   advance;
  result_t                result;
  logic [LENGTH_BITS-1:0] length_now;
  result_t                out_result;
  logic [BODY_LEN_W-1:0]  out_length;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  hrp_engine #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .data       (in_byte),
    .result     (result),
    .length_out (length_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= data_byte;
    end
    if (advance) begin
      out_result <= result;
      out_length <= BODY_LEN_W'(length_now);
    end
  end

  assign parse_status  = out_result.status;
  assign byte_role     = out_result.role;
  assign byte_out      = out_result.data;
  assign header_begin  = out_result.header_begin;
  assign version_major = out_result.major;
  assign version_minor = out_result.minor;
  assign body_length   = out_length;

endmodule
